// ----- design/load_cell_adc_reader_with_tare_macros.svh -----
// Assertion helpers for the top-level file, which carries the concurrent checks.
`ifndef LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH
`define LOAD_CELL_ADC_READER_WITH_TARE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCR_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcr check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define LCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcr check failed: next-cycle implication");

`endif

// ----- design/lcr_pkg.sv -----
package lcr_pkg;

   // Default values of the top-level parameters.
   localparam int DEF_DATA_BITS       = 24;
   localparam int DEF_MAX_SAMPLES     = 256;
   localparam int DEF_SCALE_FRAC_BITS = 16;

   // Fixed field widths.
   localparam int COUNT_BITS = 9;
   localparam int SCALE_BITS = 32;
   localparam int FORCE_BITS = 32;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [1:0] op_type;
   typedef logic [0:0] csr_index_type;

   // Operation codes carried by each input word.
   localparam op_type OP_TICK    = 2'd0;
   localparam op_type OP_TARE    = 2'd1;
   localparam op_type OP_MEASURE = 2'd2;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_SAMPLE_COUNT = 1'b0;
   localparam csr_index_type CSR_SCALE_FACTOR = 1'b1;

   // Serial interface phases.
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_WAIT      = 3'd1;
   localparam logic [2:0] PH_HIGH      = 3'd2;
   localparam logic [2:0] PH_LOW       = 3'd3;
   localparam logic [2:0] PH_GAIN_HIGH = 3'd4;
   localparam logic [2:0] PH_GAIN_LOW  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;       // apply one accepted tick
      logic div_start;  // start averaging divide
      logic avg_load;   // capture signed average
      logic mul_load;   // multiply by scale, store tare
      logic force_load; // shift and saturate product
      logic out_load;   // load output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finish;     // last tick ended a run
      logic div_done;   // divider finished
   } status_type;

endpackage

// ----- design/lcr_divider.sv -----
module lcr_divider #(
   parameter int NUM_BITS = 33,
   parameter int DEN_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic [NUM_BITS-1:0] quotient,
   output logic                done
);
   localparam int STEP_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0]  quo_ff, quo_in;
   logic [DEN_BITS-1:0]  rem_ff, rem_in;
   logic [DEN_BITS-1:0]  den_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DEN_BITS:0]    rem_shift;
   logic [DEN_BITS:0]    rem_diff;
   logic                 fits;

   // Restoring division, one quotient bit per cycle.
   assign rem_shift = {rem_ff, quo_ff[NUM_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = ~rem_diff[DEN_BITS];
   assign rem_in    = fits ? rem_diff[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
   assign quo_in    = {quo_ff[NUM_BITS-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_BITS'(NUM_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- design/lcr_datapath.sv -----
module lcr_datapath #(
   parameter int DATA_BITS       = lcr_pkg::DEF_DATA_BITS,
   parameter int MAX_SAMPLES     = lcr_pkg::DEF_MAX_SAMPLES,
   parameter int SCALE_FRAC_BITS = lcr_pkg::DEF_SCALE_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lcr_pkg::cmd_type                       cmd,
   output lcr_pkg::status_type                    status,
   input  lcr_pkg::op_type                        req_operation,
   input  logic                                   req_data_line,
   input  logic                                   csr_write,
   input  lcr_pkg::csr_index_type                 csr_index,
   input  logic [lcr_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                                   rsp_clock_line,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_result_valid,
   output logic                                   rsp_was_tare,
   output logic signed [lcr_pkg::FORCE_BITS-1:0]  rsp_force_value,
   output logic signed [DATA_BITS-1:0]            rsp_offset_value
);
   import lcr_pkg::*;

   localparam int BIT_BITS  = $clog2(DATA_BITS + 1);
   localparam int CNT_BITS  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS  = DATA_BITS + CNT_BITS;
   localparam int DIFF_BITS = DATA_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + SCALE_BITS;
   localparam logic [31:0] MAX_WIDE = 32'(MAX_SAMPLES);
   localparam logic signed [PROD_BITS-1:0] ROUND_ADD =
      PROD_BITS'((64'd1 << SCALE_FRAC_BITS) - 64'd1);
   localparam logic signed [FORCE_BITS-1:0] FORCE_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
   localparam logic signed [FORCE_BITS-1:0] FORCE_MIN = {1'b1, {(FORCE_BITS-1){1'b0}}};

   // Configuration registers.
   logic [COUNT_BITS-1:0]        sample_count_ff;
   logic signed [SCALE_BITS-1:0] scale_ff;

   // Run state.
   logic [2:0]                   phase_ff, phase_in;
   logic [BIT_BITS-1:0]          bit_ff, bit_in;
   logic [DATA_BITS-1:0]         shift_ff, shift_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [CNT_BITS-1:0]          done_ff, done_in;
   logic                         run_tare_ff, run_tare_in;
   logic signed [DATA_BITS-1:0]  tare_offset_ff;
   logic                         res_clk_ff, res_clk_in;
   logic                         finish_ff, finish_in;

   // End-of-run arithmetic.
   logic [SUM_BITS-1:0]          sum_mag;
   logic [SUM_BITS-1:0]          quotient;
   logic                         div_done;
   logic signed [DATA_BITS-1:0]  avg_ff, avg_in;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]  prod_adj;
   logic signed [PROD_BITS-1:0]  prod_shift;
   logic signed [FORCE_BITS-1:0] force_ff, force_in;

   logic [31:0]                  count_wide;
   logic [31:0]                  eff_wide;
   logic [CNT_BITS-1:0]          eff_count;

   // Zero counts as one conversion, large counts clip at the maximum.
   always_comb begin
      count_wide = 32'(sample_count_ff);
      if (count_wide == 32'd0) begin
         eff_wide = 32'd1;
      end else if (count_wide > MAX_WIDE) begin
         eff_wide = MAX_WIDE;
      end else begin
         eff_wide = count_wide;
      end
   end
   assign eff_count = eff_wide[CNT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= COUNT_BITS'(1);
         scale_ff        <= SCALE_BITS'(65536);
      end else if (csr_write) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sample_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_SCALE_FACTOR: scale_ff        <= csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // One half-bit tick of the serial interface.
   always_comb begin
      phase_in    = phase_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      sum_in      = sum_ff;
      done_in     = done_ff;
      run_tare_in = run_tare_ff;
      res_clk_in  = 1'b0;
      finish_in   = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (req_operation == OP_TARE || req_operation == OP_MEASURE) begin
               run_tare_in = (req_operation == OP_TARE);
               sum_in      = '0;
               done_in     = '0;
               bit_in      = '0;
               shift_in    = '0;
               phase_in    = PH_WAIT;
            end
         end
         PH_WAIT: begin
            if (!req_data_line) begin
               bit_in     = '0;
               shift_in   = '0;
               res_clk_in = 1'b1;
               phase_in   = PH_HIGH;
            end
         end
         PH_HIGH: begin
            shift_in = {shift_ff[DATA_BITS-2:0], req_data_line};
            bit_in   = bit_ff + 1'b1;
            phase_in = PH_LOW;
         end
         PH_LOW: begin
            res_clk_in = 1'b1;
            phase_in   = (bit_ff < BIT_BITS'(DATA_BITS)) ? PH_HIGH : PH_GAIN_HIGH;
         end
         PH_GAIN_HIGH: begin
            phase_in = PH_GAIN_LOW;
         end
         default: begin
            // Gain pulse done: accumulate the sign-extended conversion.
            sum_in  = sum_ff + {{(SUM_BITS-DATA_BITS){shift_ff[DATA_BITS-1]}}, shift_ff};
            done_in = done_ff + 1'b1;
            if (done_in >= eff_count) begin
               finish_in = 1'b1;
               phase_in  = PH_IDLE;
            end else begin
               phase_in  = PH_WAIT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_ff      <= '0;
         shift_ff    <= '0;
         sum_ff      <= '0;
         done_ff     <= '0;
         run_tare_ff <= 1'b0;
         finish_ff   <= 1'b0;
      end else if (cmd.step) begin
         phase_ff    <= phase_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         sum_ff      <= sum_in;
         done_ff     <= done_in;
         run_tare_ff <= run_tare_in;
         finish_ff   <= finish_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         res_clk_ff <= res_clk_in;
      end
   end

   // Average: divide the magnitude, then restore the sign.
   assign sum_mag = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);

   lcr_divider #(
      .NUM_BITS(SUM_BITS),
      .DEN_BITS(CNT_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(sum_mag),
      .divisor (done_ff),
      .quotient(quotient),
      .done    (div_done)
   );

   assign avg_in = sum_ff[SUM_BITS-1] ? -quotient[DATA_BITS-1:0] : quotient[DATA_BITS-1:0];

   assign diff    = {avg_ff[DATA_BITS-1], avg_ff} -
                    {tare_offset_ff[DATA_BITS-1], tare_offset_ff};
   assign prod_in = diff * scale_ff;

   // Shift right with truncation toward zero, then clip to 32 bits.
   assign prod_adj   = prod_ff[PROD_BITS-1] ? prod_ff + ROUND_ADD : prod_ff;
   assign prod_shift = prod_adj >>> SCALE_FRAC_BITS;

   always_comb begin
      if (prod_shift[PROD_BITS-1:FORCE_BITS-1] == '0 ||
          prod_shift[PROD_BITS-1:FORCE_BITS-1] == '1) begin
         force_in = prod_shift[FORCE_BITS-1:0];
      end else if (prod_shift[PROD_BITS-1]) begin
         force_in = FORCE_MIN;
      end else begin
         force_in = FORCE_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.avg_load) begin
         avg_ff <= avg_in;
      end
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
      if (cmd.force_load) begin
         force_ff <= force_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_offset_ff <= '0;
      end else if (cmd.mul_load && run_tare_ff) begin
         tare_offset_ff <= avg_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_clock_line   <= res_clk_ff;
         rsp_busy_res     <= (phase_ff != PH_IDLE);
         rsp_result_valid <= finish_ff;
         rsp_was_tare     <= finish_ff & run_tare_ff;
         rsp_force_value  <= (finish_ff && !run_tare_ff) ? force_ff : '0;
         rsp_offset_value <= tare_offset_ff;
      end
   end

   assign status.finish   = finish_ff;
   assign status.div_done = div_done;

endmodule

// ----- design/lcr_ctrl.sv -----
module lcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lcr_pkg::status_type status,
   output lcr_pkg::cmd_type    cmd
);
   import lcr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_SCALE  = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.finish) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.avg_load = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_SCALE;
         end
         S_SCALE: begin
            cmd.force_load = 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/load_cell_adc_reader_with_tare.sv -----
// Reader for a two-wire load-cell converter with tare. Every input word is one half-bit
// tick: it carries the level of the converter's data line and an operation (tick only,
// start tare, start measure; starts are ignored while a run is in progress), and it
// returns exactly one result word with the serial clock level to drive for the next
// half-bit, the busy flag, and, on the tick that ends a run, the averaged reading. A run
// takes sample_count conversions of DATA_BITS bits, each followed by one gain pulse; a
// tare stores the average as the offset, a measure returns (average - offset) times the
// signed Q16.16 scale, truncated toward zero and saturated to 32 bits. An ordinary tick
// passes through the decide and output states before the next word can be accepted, and
// waits in the output state while an earlier result is still held. The tick that ends a
// run also goes through the bit-serial divider, which forms the average one quotient
// bit per cycle, and the scale multiply. The next input word is accepted while a result
// still waits in the output register. Configuration writes are always accepted and must
// be made only while the block is idle.
`include "load_cell_adc_reader_with_tare_macros.svh"

module load_cell_adc_reader_with_tare #(
   parameter int DATA_BITS       = lcr_pkg::DEF_DATA_BITS,
   parameter int MAX_SAMPLES     = lcr_pkg::DEF_MAX_SAMPLES,
   parameter int SCALE_FRAC_BITS = lcr_pkg::DEF_SCALE_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Tick input channel.
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  lcr_pkg::op_type                        req_operation,
   input  logic                                   req_data_line,
   // Result channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_clock_line,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_result_valid,
   output logic                                   rsp_was_tare,
   output logic signed [lcr_pkg::FORCE_BITS-1:0]  rsp_force_value,
   output logic signed [DATA_BITS-1:0]            rsp_offset_value,
   // Configuration write channel.
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  lcr_pkg::csr_index_type                 csr_index,
   input  logic [lcr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import lcr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes go straight into the configuration registers, so the port is always ready.
   assign csr_ready = 1'b1;

   // The controller sequences each tick and the end-of-run arithmetic.
   lcr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the serial interface state, the accumulator, the divider,
   // the scale multiplier and the output register.
   lcr_datapath #(
      .DATA_BITS      (DATA_BITS),
      .MAX_SAMPLES    (MAX_SAMPLES),
      .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_data_line   (req_data_line),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_clock_line  (rsp_clock_line),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_result_valid(rsp_result_valid),
      .rsp_was_tare    (rsp_was_tare),
      .rsp_force_value (rsp_force_value),
      .rsp_offset_value(rsp_offset_value)
   );

   // A finished run leaves the block idle.
   `LCR_ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid && rsp_result_valid, !rsp_busy_res)
   // A tare result never carries a force value.
   `LCR_ASSERT_IMPLIES(a_tare_zero_force, clock, reset, rsp_valid && rsp_was_tare, rsp_force_value == '0)
   // Loading the output register always presents a word on the next cycle.
   `LCR_ASSERT_NEXT(a_out_load_valid, clock, reset, cmd.out_load, rsp_valid)
   // Each accepted tick keeps the input closed while it is worked on.
   `LCR_ASSERT_NEXT(a_accept_closes, clock, reset, req_valid && req_ready, !req_ready)

endmodule
